[sv/odo_pkg.sv]
// Shared types, constants and tables for the differential-drive odometry block.
package odo_pkg;

   // Number of CORDIC rotations per heading.
   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W = $clog2(CORDIC_STEPS);

   // Shared divider geometry.
   localparam int DIV_W = 48;
   localparam int DVS_W = 31;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Angle constants: Q3.28 for headings, Q2.30 inside the CORDIC.
   localparam logic [30:0] PI_Q28 = 31'd843314857;
   localparam logic [30:0] TWO_PI_Q28 = 31'd1686629714;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

   // Reciprocal of a full turn scaled by 2^62, rounded down so that the
   // quotient estimate is never too large and at most one short.
   localparam logic [31:0] TWO_PI_RCP = 32'd2734261000;

   // Configuration register indexes and reset values.
   localparam logic CSR_RADIUS = 1'b0;
   localparam logic CSR_GAIN = 1'b1;
   localparam logic [15:0] RADIUS_RESET = 16'd100;
   localparam logic [17:0] GAIN_RESET = 18'd65536;

   localparam logic FUNC_STEP = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PROD,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_MOD_ABS,
      ST_MOD_RCP,
      ST_MOD_MUL,
      ST_MOD_SUB,
      ST_MOD_FIX,
      ST_CORD_INIT,
      ST_CORD,
      ST_MULX,
      ST_MULY,
      ST_DONE
   } state_type;

   // Request into the shared divider.
   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   // Result out of the shared divider.
   typedef struct packed {
      logic done;
      logic [DIV_W-1:0] quotient;
      logic [DVS_W-1:0] remainder;
   } div_rsp_type;

   // Arctangent of 2^-i in Q2.30.
   function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] i);
      logic signed [33:0] r;
      begin
         unique case (i)
            5'd0: r = 34'sd843314857;
            5'd1: r = 34'sd497837829;
            5'd2: r = 34'sd263043837;
            5'd3: r = 34'sd133525159;
            5'd4: r = 34'sd67021687;
            5'd5: r = 34'sd33543516;
            5'd6: r = 34'sd16775851;
            5'd7: r = 34'sd8388437;
            5'd8: r = 34'sd4194283;
            5'd9: r = 34'sd2097149;
            5'd10: r = 34'sd1048576;
            5'd11: r = 34'sd524288;
            5'd12: r = 34'sd262144;
            5'd13: r = 34'sd131072;
            5'd14: r = 34'sd65536;
            5'd15: r = 34'sd32768;
            5'd16: r = 34'sd16384;
            5'd17: r = 34'sd8192;
            5'd18: r = 34'sd4096;
            5'd19: r = 34'sd2048;
            5'd20: r = 34'sd1024;
            5'd21: r = 34'sd512;
            5'd22: r = 34'sd256;
            5'd23: r = 34'sd128;
            5'd24: r = 34'sd64;
            5'd25: r = 34'sd32;
            5'd26: r = 34'sd16;
            5'd27: r = 34'sd8;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            default: r = 34'sd0;
         endcase
         return r;
      end
   endfunction

endpackage

[sv/differential_drive_odometry.sv]
// Top level of the differential-drive dead-reckoning odometry block.
//
// Usage: items arrive on the req_ channel (valid/ready). A step item
// (req_func low) carries two wheel speeds; a load item (req_func high)
// sets x, y and heading. Each item returns one pose on the rsp_ channel.
// The csr_ port writes chassis_radius (index 0) and angle_gain (index 1);
// the user must write them only while the block is idle; the block itself does not enforce it.
// A step item runs the 48-step restoring divider for the heading change,
// which dominates a step, then the wrap (absolute value, reciprocal
// estimate, multiply, subtract, correction), the CORDIC and the
// multiplies of the mean speed by cosine and sine. A load item runs
// only the wrap on its heading.
// The block takes one item at a time; req_ready is high only when idle,
// so it takes no new item before the last one is through.
// The result sits in an output register, so a new item may be taken
// while the last result waits; an item that finishes while that result
// is still held holds until the output register is free.
// Reset clears the pose to zero, restores the register defaults and
// drops rsp_valid.
module differential_drive_odometry
   import odo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [15:0] req_first_speed,
   input  logic signed [15:0] req_second_speed,
   input  logic signed [31:0] req_load_x,
   input  logic signed [31:0] req_load_y,
   input  logic signed [31:0] req_load_heading,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_pos_x_out,
   output logic signed [31:0] rsp_pos_y_out,
   output logic signed [31:0] rsp_heading_out,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [17:0]        csr_data
);

   state_type state_ff, state_in;

   logic [15:0] radius_ff;
   logic [17:0] gain_ff;

   logic [31:0] pos_x_ff, pos_y_ff;
   logic signed [31:0] heading_ff;

   logic rsp_valid_ff;
   logic [31:0] rsp_x_ff, rsp_y_ff, rsp_h_ff;

   logic func_ff;
   logic [31:0] ldx_ff, ldy_ff;
   logic signed [15:0] mean_ff;
   logic [15:0] dmag_ff;
   logic dneg_ff;
   logic [33:0] prod_ff;
   logic signed [47:0] r_ff;
   logic rneg_ff;
   logic [47:0] rabs_ff;
   logic [15:0] qest_ff;
   logic [46:0] qt_ff;
   logic [31:0] rem_ff;
   logic signed [31:0] hnew_ff;

   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic cneg_ff;
   logic [STEP_W-1:0] it_ff;

   logic signed [49:0] mprod_ff;
   logic [31:0] dx_ff;

   div_req_type div_req;
   div_rsp_type div_rsp;

   logic accept;
   logic slot_free;
   logic commit;

   logic signed [16:0] sum_w, diff_w;
   logic signed [47:0] dang_w;
   logic [61:0] rcp_w;
   logic [31:0] rem1_w;
   logic [31:0] hfold_w;
   logic signed [33:0] z0_w;
   logic signed [33:0] sx_w, sy_w;
   logic signed [33:0] mul_op_w;
   logic signed [49:0] mul_w;
   logic [31:0] trunc_w;

   odo_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign accept = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_func == FUNC_LOAD) ? ST_MOD_ABS : ST_PROD;
            end
         end
         ST_PROD: state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = ST_MOD_ABS;
            end
         end
         ST_MOD_ABS: state_in = ST_MOD_RCP;
         ST_MOD_RCP: state_in = ST_MOD_MUL;
         ST_MOD_MUL: state_in = ST_MOD_SUB;
         ST_MOD_SUB: state_in = ST_MOD_FIX;
         ST_MOD_FIX: state_in = (func_ff == FUNC_LOAD) ? ST_DONE : ST_CORD_INIT;
         ST_CORD_INIT: state_in = ST_CORD;
         ST_CORD: begin
            if (it_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_MULX;
            end
         end
         ST_MULX: state_in = ST_MULY;
         ST_MULY: state_in = ST_DONE;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      commit = 1'b0;
      div_req.start = 1'b0;
      div_req.dividend = {3'b000, prod_ff, 11'b0};
      div_req.divisor = {15'b0, (radius_ff == 16'd0) ? 16'd1 : radius_ff};
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DIV_GO: div_req.start = 1'b1;
         ST_DONE: commit = slot_free;
         default: ;
      endcase
   end

   // Input preparation, heading change, wrap and CORDIC fold.
   always_comb begin
      sum_w = 17'(req_first_speed) + 17'(req_second_speed);
      diff_w = 17'(req_first_speed) - 17'(req_second_speed);
      dang_w = dneg_ff ? -$signed({1'b0, div_rsp.quotient[46:0]})
                       : $signed({1'b0, div_rsp.quotient[46:0]});
      // Quotient estimate from the upper bits, at most one turn short.
      rcp_w = 62'(rabs_ff[45:16]) * 62'(TWO_PI_RCP);
      rem1_w = (rem_ff >= 32'(TWO_PI_Q28)) ? rem_ff - 32'(TWO_PI_Q28) : rem_ff;
      // Floor remainder folded straight into [-pi, pi).
      hfold_w = (rneg_ff && rem1_w != '0) ? 32'(PI_Q28) - rem1_w
                                          : rem1_w - 32'(PI_Q28);
      z0_w = 34'(hnew_ff) <<< 2;
   end

   // Shared shifter for one rotation.
   assign sx_w = cx_ff >>> it_ff;
   assign sy_w = cy_ff >>> it_ff;

   // Shared multiplier: move times cosine, then move times sine.
   assign mul_op_w = (state_ff == ST_MULX) ? (cneg_ff ? -cx_ff : cx_ff)
                                           : (cneg_ff ? -cy_ff : cy_ff);
   assign mul_w = 50'(mean_ff) * 50'(mul_op_w);
   assign trunc_w = mprod_ff[49] ? 32'((mprod_ff + 50'sd1073741823) >>> 30)
                                 : 32'(mprod_ff >>> 30);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radius_ff <= RADIUS_RESET;
         gain_ff <= GAIN_RESET;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         heading_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_RADIUS: radius_ff <= csr_data[15:0];
               CSR_GAIN: gain_ff <= csr_data;
               default: ;
            endcase
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
            heading_ff <= hnew_ff;
            if (func_ff == FUNC_LOAD) begin
               pos_x_ff <= ldx_ff;
               pos_y_ff <= ldy_ff;
            end else begin
               pos_x_ff <= pos_x_ff + dx_ff;
               pos_y_ff <= pos_y_ff + trunc_w;
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         ldx_ff <= req_load_x;
         ldy_ff <= req_load_y;
         mean_ff <= 16'((sum_w + 17'(sum_w[16])) >>> 1);
         dneg_ff <= diff_w[16];
         dmag_ff <= diff_w[16] ? 16'(-diff_w) : diff_w[15:0];
         r_ff <= 48'(req_load_heading) + 48'(PI_Q28);
      end
      unique case (state_ff)
         ST_PROD: prod_ff <= 34'(dmag_ff) * 34'(gain_ff);
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               r_ff <= 48'(heading_ff) + dang_w + 48'(PI_Q28);
            end
         end
         ST_MOD_ABS: begin
            rneg_ff <= r_ff[47];
            rabs_ff <= r_ff[47] ? 48'(-r_ff) : 48'(r_ff);
         end
         ST_MOD_RCP: qest_ff <= rcp_w[61:46];
         ST_MOD_MUL: qt_ff <= 47'(qest_ff) * 47'(TWO_PI_Q28);
         ST_MOD_SUB: rem_ff <= 32'(rabs_ff - 48'(qt_ff));
         ST_MOD_FIX: hnew_ff <= hfold_w;
         ST_CORD_INIT: begin
            cx_ff <= CORDIC_K_Q30;
            cy_ff <= '0;
            it_ff <= '0;
            if (z0_w > HALF_PI_Q30) begin
               cz_ff <= z0_w - PI_Q30;
               cneg_ff <= 1'b1;
            end else if (z0_w < -HALF_PI_Q30) begin
               cz_ff <= z0_w + PI_Q30;
               cneg_ff <= 1'b1;
            end else begin
               cz_ff <= z0_w;
               cneg_ff <= 1'b0;
            end
         end
         ST_CORD: begin
            it_ff <= it_ff + 1'b1;
            if (!cz_ff[33]) begin
               cx_ff <= cx_ff - sy_w;
               cy_ff <= cy_ff + sx_w;
               cz_ff <= cz_ff - atan_q30(it_ff);
            end else begin
               cx_ff <= cx_ff + sy_w;
               cy_ff <= cy_ff - sx_w;
               cz_ff <= cz_ff + atan_q30(it_ff);
            end
         end
         ST_MULX: mprod_ff <= mul_w;
         ST_MULY: begin
            dx_ff <= trunc_w;
            mprod_ff <= mul_w;
         end
         default: ;
      endcase
      if (commit) begin
         rsp_h_ff <= hnew_ff;
         if (func_ff == FUNC_LOAD) begin
            rsp_x_ff <= ldx_ff;
            rsp_y_ff <= ldy_ff;
         end else begin
            rsp_x_ff <= pos_x_ff + dx_ff;
            rsp_y_ff <= pos_y_ff + trunc_w;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x_out = rsp_x_ff;
   assign rsp_pos_y_out = rsp_y_ff;
   assign rsp_heading_out = rsp_h_ff;

endmodule

[sv/odo_div.sv]
// Restoring divider, one quotient bit per cycle, for the heading change.
module odo_div
   import odo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0] trial;
   logic fits;

   // One shift, compare and subtract step.
   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      fits = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quo_in = req.dividend;
         rem_in = '0;
         dvs_in = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand and partial result registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

[sv/odo_checker.sv]
// Port-level checks for the odometry block, bound to the top level.
module odo_checker
   import odo_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_pos_x_out,
   input logic signed [31:0] rsp_heading_out
);

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x_out)
         && $stable(rsp_heading_out))
      else $error("stalled result changed");

   // The block is busy right after an input transfer.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after transfer");

   // No result appears in the cycle after a transfer into an empty output.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

   // Returned heading lies in the wrapped range.
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_out >= -$signed({1'b0, PI_Q28}))
         && (rsp_heading_out < $signed({1'b0, PI_Q28})))
      else $error("heading out of range");

endmodule

bind differential_drive_odometry odo_checker u_odo_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pos_x_out   (rsp_pos_x_out),
   .rsp_heading_out (rsp_heading_out)
);

[verif/tb_top.sv]
// Self-checking testbench for the differential-drive odometry block.
`timescale 1ns / 1ps

module tb_top;
   import odo_pkg::*;

   localparam longint PI_TURN = 843314857;
   localparam longint FULL_TURN = 2 * PI_TURN;
   localparam longint HALF_PI_FINE = 1686629713;
   localparam longint PI_FINE = 64'sd3373259426;
   localparam longint CORDIC_SCALE = 652032874;

   typedef struct {
      logic func;
      logic signed [15:0] first_speed;
      logic signed [15:0] second_speed;
      logic signed [31:0] load_x;
      logic signed [31:0] load_y;
      logic signed [31:0] load_heading;
   } odo_item_type;

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] hdg;
   } pose_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_func = 1'b0;
   logic signed [15:0] req_first_speed = '0;
   logic signed [15:0] req_second_speed = '0;
   logic signed [31:0] req_load_x = '0;
   logic signed [31:0] req_load_y = '0;
   logic signed [31:0] req_load_heading = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_pos_x_out;
   logic signed [31:0] rsp_pos_y_out;
   logic signed [31:0] rsp_heading_out;
   logic csr_write_en = 1'b0;
   logic csr_index = 1'b0;
   logic [17:0] csr_data = '0;

   odo_item_type pending_items[$];
   pose_type expected_poses[$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // Predictor state and configuration.
   logic [31:0] model_x, model_y;
   logic signed [31:0] model_hdg;
   logic [15:0] model_radius;
   logic [17:0] model_gain;

   differential_drive_odometry uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("tb_top: FAIL");
      $finish;
   end

   // Arithmetic shift right on a signed 64-bit value.
   function automatic longint shift_right(longint v, int s);
      return v >>> s;
   endfunction

   // Reduce a heading into [-pi, pi).
   function automatic logic signed [31:0] wrap_heading(longint v);
      longint r;
      r = (v + PI_TURN) % FULL_TURN;
      if (r < 0) r += FULL_TURN;
      return 32'(r - PI_TURN);
   endfunction

   // Rotation-mode CORDIC giving cosine and sine in Q1.30.
   function automatic void rotate_heading(logic signed [31:0] hdg,
                                          output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(hdg) * 4;
      flip = 0;
      x = CORDIC_SCALE;
      y = 0;
      if (z > HALF_PI_FINE) begin
         z -= PI_FINE;
         flip = 1;
      end else if (z < -HALF_PI_FINE) begin
         z += PI_FINE;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
         dx = shift_right(y, i);
         dy = shift_right(x, i);
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= longint'(atan_q30(STEP_W'(i)));
         end else begin
            x += dx;
            y -= dy;
            z += longint'(atan_q30(STEP_W'(i)));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // Advance the predicted pose by one item and queue the resulting pose.
   function automatic void predict_pose(odo_item_type it);
      longint s1, s2, mean, dvs, dang, c, s;
      pose_type p;
      if (it.func == FUNC_LOAD) begin
         model_x = it.load_x;
         model_y = it.load_y;
         model_hdg = wrap_heading(longint'(it.load_heading));
      end else begin
         s1 = it.first_speed;
         s2 = it.second_speed;
         mean = (s1 + s2) / 2;
         dvs = (model_radius != 0) ? longint'(model_radius) : 1;
         dang = ((s1 - s2) * longint'(model_gain) * 2048) / dvs;
         model_hdg = wrap_heading(longint'(model_hdg) + dang);
         rotate_heading(model_hdg, c, s);
         model_x = model_x + 32'((mean * c) / (64'sd1 << 30));
         model_y = model_y + 32'((mean * s) / (64'sd1 << 30));
      end
      p.x = model_x;
      p.y = model_y;
      p.hdg = model_hdg;
      expected_poses.push_back(p);
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
      error_count++;
   endtask

   // Driver: presents queued items and predicts each one at its transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_pose('{req_func, req_first_speed, req_second_speed,
                                       req_load_x, req_load_y, req_load_heading});
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            odo_item_type it;
            it = pending_items.pop_front();
            req_valid <= 1'b1;
            req_func <= it.func;
            req_first_speed <= it.first_speed;
            req_second_speed <= it.second_speed;
            req_load_x <= it.load_x;
            req_load_y <= it.load_y;
            req_load_heading <= it.load_heading;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transfer and picks the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_poses.size() == 0) begin
            $display("unexpected result transfer");
            error_count++;
         end else begin
            pose_type p;
            p = expected_poses.pop_front();
            if (rsp_pos_x_out !== p.x) report_mismatch("pos_x", rsp_pos_x_out, p.x);
            if (rsp_pos_y_out !== p.y) report_mismatch("pos_y", rsp_pos_y_out, p.y);
            if (rsp_heading_out !== p.hdg)
               report_mismatch("heading", rsp_heading_out, p.hdg);
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic odo_item_type step_item(int a, int b);
      odo_item_type it;
      it = '{FUNC_STEP, 16'(a), 16'(b), 32'($urandom), 32'($urandom), 32'($urandom)};
      return it;
   endfunction

   function automatic odo_item_type load_item(logic [31:0] x, logic [31:0] y,
                                              logic [31:0] h);
      odo_item_type it;
      it = '{FUNC_LOAD, 16'($urandom), 16'($urandom), x, y, h};
      return it;
   endfunction

   function automatic odo_item_type random_item();
      int r;
      r = $urandom_range(99);
      if (r < 10) return load_item($urandom, $urandom, $urandom);
      if (r < 15) return load_item($urandom, $urandom,
                                   32'($urandom_range(1686629713) - 843314857));
      if (r < 25) return step_item($urandom_range(1) ? 32767 : -32768,
                                   $urandom_range(1) ? 32767 : -32768);
      if (r < 60) return step_item($signed(16'($urandom_range(400))) - 200,
                                   $signed(16'($urandom_range(400))) - 200);
      return step_item($urandom, $urandom);
   endfunction

   // Wait until every queued item has been sent and answered, then settle.
   // The check runs between edges so that it sees the settled queues.
   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_poses.size() > 0)
         @(negedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [17:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      model_radius = (idx == CSR_RADIUS) ? val[15:0] : model_radius;
      model_gain = (idx == CSR_GAIN) ? val : model_gain;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   initial begin
      int radius_set[6] = '{1, 65535, 100, 0, 7, 1000};
      int gain_set[6] = '{262143, 0, 65536, 1, 200000, 30000};
      model_x = 0;
      model_y = 0;
      model_hdg = 0;
      model_radius = RADIUS_RESET;
      model_gain = GAIN_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, loads out of range, large turns, zero move.
      pending_items.push_back(step_item(0, 0));
      pending_items.push_back(step_item(100, 100));
      pending_items.push_back(step_item(32767, 32767));
      pending_items.push_back(step_item(-32768, -32768));
      pending_items.push_back(step_item(32767, -32768));
      pending_items.push_back(step_item(-32768, 32767));
      pending_items.push_back(step_item(-1, 0));
      pending_items.push_back(step_item(3, -4));
      pending_items.push_back(load_item(32'h7fffffff, 32'h80000000, 32'h7fffffff));
      pending_items.push_back(step_item(32767, 32767));
      pending_items.push_back(load_item(32'h80000000, 32'h7fffffff, 32'h80000000));
      pending_items.push_back(step_item(-32768, -32768));
      pending_items.push_back(load_item(0, 0, 32'd843314857));
      pending_items.push_back(load_item(0, 0, -32'sd843314857));
      pending_items.push_back(step_item(200, 200));
      pending_items.push_back(load_item(1, 2, 32'd421657428));
      pending_items.push_back(step_item(500, 500));
      pending_items.push_back(load_item(-5, 7, -32'sd421657429));
      pending_items.push_back(step_item(500, 480));
      pending_items.push_back(load_item(32'hffffffff, 0, 32'd1686629714));
      drain();

      // Random phases over several register settings and idle patterns.
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_RADIUS, 18'(radius_set[ph]));
         write_csr(CSR_GAIN, 18'(gain_set[ph]));
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 66; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 66; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         for (int n = 0; n < 280; n++) pending_items.push_back(random_item());
         drain();
      end

      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
